[src/i2cee_pkg.sv]
// Shared types and constants for the I2C EEPROM byte master.
`default_nettype none
package i2cee_pkg;

   localparam int STEP_W    = 3;
   localparam int BC_W      = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 8;

   // bus segment of a transaction; START1 with step zero is idle
   typedef enum logic [2:0] {
      SEG_START1 = 3'd0,
      SEG_DEVW   = 3'd1,
      SEG_ADDR   = 3'd2,
      SEG_DATA   = 3'd3,
      SEG_START2 = 3'd4,
      SEG_DEVR   = 3'd5,
      SEG_READ   = 3'd6,
      SEG_STOP   = 3'd7
   } seg_type;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_0 = 3'd0;
   localparam step_type STEP_1 = 3'd1;
   localparam step_type STEP_2 = 3'd2;
   localparam step_type STEP_3 = 3'd3;
   localparam step_type STEP_4 = 3'd4;
   localparam step_type STEP_5 = 3'd5;

   localparam logic [BC_W-1:0] BIT_COUNT_FULL = 4'd8;

   localparam logic [6:0] DEV_ADDR_RESET    = 7'd80;
   localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd200;

   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_TIMEOUT    = 1'b1;

   typedef struct packed {
      logic       scl_level;
      logic       sda_release;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       nack_error;
   } rsp_type;

endpackage
`default_nettype wire

[src/i2c_eeprom_byte_master_unit.sv]
// Top level: tick-driven I2C master for random byte read/write of a 256-byte EEPROM.
`default_nettype none
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  req_    | in        | req_valid/req_stall| start_request, opcode, mem_address,
//          |           |                    | write_byte, sda_sample (one bus tick)
//  rsp_    | out       | rsp_valid/rsp_stall| scl_level, sda_release, busy_res,
//          |           |                    | done_res, read_byte, nack_error
//  csr_    | in        | csr_valid/csr_ready| csr_index (0 device address, 1 timeout),
//          |           |                    | csr_wdata
//
//  Each accepted request advances the bus sequencer by at most one step and
//  yields one registered response; one request per clock while req_stall is low.
//  The response path is a two-entry buffer (output register plus skid entry),
//  so req_stall rises only when both entries hold undelivered responses.
//  Synchronous active-high reset: idle, both bus lines released, registers
//  at their defaults (device address 80, acknowledge timeout 200).
//  csr_ready is always high; writes take effect on the next clock.
//
module i2c_eeprom_byte_master_unit
   import i2cee_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,

   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire                  req_start_request,
   input  wire                  req_opcode,
   input  wire [7:0]            req_mem_address,
   input  wire [7:0]            req_write_byte,
   input  wire                  req_sda_sample,

   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic                 rsp_scl_level,
   output logic                 rsp_sda_release,
   output logic                 rsp_busy_res,
   output logic                 rsp_done_res,
   output logic [7:0]           rsp_read_byte,
   output logic                 rsp_nack_error,

   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [CSR_DAT_W-1:0]  csr_wdata
);

   // configuration registers
   logic [6:0] dev_addr_ff;
   logic [7:0] ack_timeout_ff;

   // sequencer state
   seg_type        seg_ff,      seg_in;
   step_type       step_ff,     step_in;
   logic [BC_W-1:0] bit_count_ff, bit_count_in;
   logic [7:0]     shift_ff,    shift_in;
   logic [7:0]     wait_ff,     wait_in;
   logic           lat_op_ff,   lat_op_in;
   logic [7:0]     lat_addr_ff, lat_addr_in;
   logic [7:0]     lat_data_ff, lat_data_in;
   logic [7:0]     recv_ff,     recv_in;
   logic           err_ff,      err_in;
   logic           scl_ff,      scl_in;
   logic           sda_ff,      sda_in;
   logic           done_in;

   // response buffer
   rsp_type rsp_new;
   rsp_type rsp_ff;
   rsp_type skid_ff;
   logic    rsp_valid_ff;
   logic    skid_valid_ff;

   logic    req_accept;
   logic    rsp_fire;

   logic [BC_W-1:0]   bc_inc;
   step_type          start_step;
   logic              is_idle;

   assign csr_ready  = 1'b1;
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign rsp_fire   = rsp_valid_ff && !rsp_stall;

   assign bc_inc     = bit_count_ff + 4'd1;
   // START1 step zero is idle, so its bus steps sit one code higher than START2's
   assign start_step = (seg_ff == SEG_START1) ? step_type'(step_ff - STEP_1) : step_ff;
   assign is_idle    = (seg_ff == SEG_START1) && (step_ff == STEP_0);

   // ---------------------------------------------------------------------
   // next state: one bus step per accepted request
   // ---------------------------------------------------------------------
   always_comb begin
      seg_in       = seg_ff;
      step_in      = step_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      wait_in      = wait_ff;
      lat_op_in    = lat_op_ff;
      lat_addr_in  = lat_addr_ff;
      lat_data_in  = lat_data_ff;
      recv_in      = recv_ff;
      err_in       = err_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      done_in      = 1'b0;

      case (seg_ff)
         SEG_START1, SEG_START2: begin
            if (is_idle) begin
               if (req_start_request) begin
                  lat_op_in   = req_opcode;
                  lat_addr_in = req_mem_address;
                  lat_data_in = req_write_byte;
                  err_in      = 1'b0;
                  step_in     = STEP_1;
               end
            end else begin
               case (start_step)
                  STEP_0: begin
                     sda_in  = 1'b1;
                     step_in = step_type'(step_ff + STEP_1);
                  end
                  STEP_1: begin
                     scl_in  = 1'b1;
                     step_in = step_type'(step_ff + STEP_1);
                  end
                  STEP_2: begin
                     sda_in  = 1'b0;
                     step_in = step_type'(step_ff + STEP_1);
                  end
                  STEP_3: begin
                     // START done: load the device byte, R/W bit from the segment
                     scl_in       = 1'b0;
                     step_in      = STEP_0;
                     bit_count_in = '0;
                     if (seg_ff == SEG_START1) begin
                        seg_in   = SEG_DEVW;
                        shift_in = {dev_addr_ff, 1'b0};
                     end else begin
                        seg_in   = SEG_DEVR;
                        shift_in = {dev_addr_ff, 1'b1};
                     end
                  end
                  default: begin
                     seg_in  = SEG_START1;
                     step_in = STEP_0;
                     scl_in  = 1'b1;
                     sda_in  = 1'b1;
                  end
               endcase
            end
         end

         SEG_DEVW, SEG_ADDR, SEG_DATA, SEG_DEVR: begin
            case (step_ff)
               STEP_0: begin
                  sda_in  = shift_ff[7];
                  step_in = STEP_1;
               end
               STEP_1: begin
                  scl_in  = 1'b1;
                  step_in = STEP_2;
               end
               STEP_2: begin
                  scl_in       = 1'b0;
                  shift_in     = {shift_ff[6:0], 1'b0};
                  bit_count_in = bc_inc;
                  step_in      = (bc_inc >= BIT_COUNT_FULL) ? STEP_3 : STEP_0;
               end
               STEP_3: begin
                  sda_in  = 1'b1;
                  step_in = STEP_4;
               end
               STEP_4: begin
                  scl_in  = 1'b1;
                  wait_in = '0;
                  step_in = STEP_5;
               end
               STEP_5: begin
                  // acknowledge window: slave low, or timeout gives a sticky error
                  if (!req_sda_sample || (wait_ff >= ack_timeout_ff)) begin
                     if (req_sda_sample) begin
                        err_in = 1'b1;
                     end
                     scl_in  = 1'b0;
                     step_in = STEP_0;
                     case (seg_ff)
                        SEG_DEVW: begin
                           seg_in       = SEG_ADDR;
                           shift_in     = lat_addr_ff;
                           bit_count_in = '0;
                        end
                        SEG_ADDR: begin
                           if (lat_op_ff) begin
                              seg_in = SEG_START2;
                           end else begin
                              seg_in       = SEG_DATA;
                              shift_in     = lat_data_ff;
                              bit_count_in = '0;
                           end
                        end
                        SEG_DATA: begin
                           seg_in = SEG_STOP;
                        end
                        default: begin
                           seg_in       = SEG_READ;
                           shift_in     = '0;
                           bit_count_in = '0;
                        end
                     endcase
                  end else begin
                     wait_in = wait_ff + 8'd1;
                  end
               end
               default: begin
                  seg_in  = SEG_START1;
                  step_in = STEP_0;
                  scl_in  = 1'b1;
                  sda_in  = 1'b1;
               end
            endcase
         end

         SEG_READ: begin
            case (step_ff)
               STEP_0: begin
                  sda_in  = 1'b1;
                  step_in = STEP_1;
               end
               STEP_1: begin
                  scl_in  = 1'b1;
                  step_in = STEP_2;
               end
               STEP_2: begin
                  shift_in = {shift_ff[6:0], req_sda_sample};
                  step_in  = STEP_3;
               end
               STEP_3: begin
                  scl_in       = 1'b0;
                  bit_count_in = bc_inc;
                  if (bc_inc >= BIT_COUNT_FULL) begin
                     recv_in = shift_ff;
                     step_in = STEP_4;
                  end else begin
                     step_in = STEP_1;
                  end
               end
               STEP_4: begin
                  // acknowledge clock with the line released: master NACK
                  sda_in  = 1'b1;
                  scl_in  = 1'b1;
                  step_in = STEP_5;
               end
               STEP_5: begin
                  scl_in  = 1'b0;
                  seg_in  = SEG_STOP;
                  step_in = STEP_0;
               end
               default: begin
                  seg_in  = SEG_START1;
                  step_in = STEP_0;
                  scl_in  = 1'b1;
                  sda_in  = 1'b1;
               end
            endcase
         end

         SEG_STOP: begin
            case (step_ff)
               STEP_0: begin
                  sda_in  = 1'b0;
                  step_in = STEP_1;
               end
               STEP_1: begin
                  scl_in  = 1'b1;
                  step_in = STEP_2;
               end
               STEP_2: begin
                  sda_in  = 1'b1;
                  done_in = 1'b1;
                  seg_in  = SEG_START1;
                  step_in = STEP_0;
               end
               default: begin
                  seg_in  = SEG_START1;
                  step_in = STEP_0;
                  scl_in  = 1'b1;
                  sda_in  = 1'b1;
               end
            endcase
         end

         default: begin
            seg_in  = SEG_START1;
            step_in = STEP_0;
            scl_in  = 1'b1;
            sda_in  = 1'b1;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // outputs: response built from the post-step state
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_new.scl_level   = scl_in;
      rsp_new.sda_release = sda_in;
      rsp_new.busy_res    = !((seg_in == SEG_START1) && (step_in == STEP_0));
      rsp_new.done_res    = done_in;
      rsp_new.read_byte   = recv_in;
      rsp_new.nack_error  = err_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff    <= DEV_ADDR_RESET;
         ack_timeout_ff <= ACK_TIMEOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEVICE_ADDRESS: dev_addr_ff    <= csr_wdata[6:0];
            CSR_ACK_TIMEOUT:    ack_timeout_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // sequencer registers, advanced only by an accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff       <= SEG_START1;
         step_ff      <= STEP_0;
         bit_count_ff <= '0;
         shift_ff     <= '0;
         wait_ff      <= '0;
         lat_op_ff    <= 1'b0;
         lat_addr_ff  <= '0;
         lat_data_ff  <= '0;
         recv_ff      <= '0;
         err_ff       <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
      end else if (req_accept) begin
         seg_ff       <= seg_in;
         step_ff      <= step_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         wait_ff      <= wait_in;
         lat_op_ff    <= lat_op_in;
         lat_addr_ff  <= lat_addr_in;
         lat_data_ff  <= lat_data_in;
         recv_ff      <= recv_in;
         err_ff       <= err_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
      end
   end

   // response buffer: output register plus one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_fire) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (req_accept) begin
         if (!rsp_valid_ff || rsp_fire) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_fire) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_fire) begin
            rsp_ff <= skid_ff;
         end
      end else if (req_accept) begin
         if (!rsp_valid_ff || rsp_fire) begin
            rsp_ff <= rsp_new;
         end else begin
            skid_ff <= rsp_new;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_scl_level   = rsp_ff.scl_level;
   assign rsp_sda_release = rsp_ff.sda_release;
   assign rsp_busy_res    = rsp_ff.busy_res;
   assign rsp_done_res    = rsp_ff.done_res;
   assign rsp_read_byte   = rsp_ff.read_byte;
   assign rsp_nack_error  = rsp_ff.nack_error;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry holds a response while output register is empty");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_idle_released: assert property (@(posedge clock) disable iff (reset)
      is_idle |-> (scl_ff && sda_ff))
      else $error("bus lines not released while idle");

   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= BIT_COUNT_FULL)
      else $error("bit counter ran past one byte");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.done_res) |-> !rsp_ff.busy_res)
      else $error("STOP completion reported while still busy");

endmodule
`default_nettype wire
